// ----- src/sstc_pkg.sv -----
// Shared types and constants for the swept sphere contact time core.
`default_nettype none
package sstc_pkg;

  // Item command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  // Divider produces this many quotient bits (Q8.16 time)
  localparam int TIME_W = 24;
  localparam logic [4:0] DIV_LAST = 5'(TIME_W - 1);

  // Square root iteration counts
  localparam logic [6:0] SQRT_STEPS_FULL = 7'd66;
  localparam logic [6:0] SQRT_STEPS_HALF = 7'd33;

  typedef enum logic [2:0] {
    OC_HIT        = 3'd0,
    OC_NO_MOTION  = 3'd1,
    OC_OVERLAP    = 3'd2,
    OC_SEPARATING = 3'd3,
    OC_OUT_REACH  = 3'd4,
    OC_NO_ROOT    = 3'd5,
    OC_NO_TARGET  = 3'd6
  } outcome_t;

  // Products formed on the shared multiplier, in issue order
  typedef enum logic [3:0] {
    SEL_VV0, SEL_DD0, SEL_DV0,
    SEL_VV1, SEL_DD1, SEL_DV1,
    SEL_VV2, SEL_DD2, SEL_DV2,
    SEL_RR, SEL_REACH, SEL_BB, SEL_AC
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_MUL_WAIT, ST_CHECK, ST_SQRT_A, ST_SQRT_A_WAIT,
    ST_CHK_REACH, ST_CHK_ROOT, ST_SQRT_D, ST_SQRT_D_WAIT, ST_DIV, ST_RESULT
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     calc_c;
    logic     sqrt_start;
    logic     sqrt_disc;
    logic     calc_reach;
    logic     calc_disc;
    logic     div_init;
    logic     div_step;
    logic     res_write;
    outcome_t res_outcome;
  } dp_cmd_t;

  typedef struct packed {
    logic loaded;
    logic mul_done;
    logic sqrt_done;
    logic no_motion;
    logic overlap;
    logic separating;
    logic out_reach;
    logic no_root;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- src/sstc_mul.sv -----
// Sequenced 66x66 unsigned multiplier built on one 33x33 multiplier.
`default_nettype none
module sstc_mul
  import sstc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [65:0]  x,
  input  wire logic [65:0]  y,
  output logic              done,
  output logic [131:0]      product
);

  logic [65:0]  xq, yq;
  logic [2:0]   cnt;
  logic         busy;
  logic [65:0]  pp;
  logic [1:0]   pp_sh;
  logic [32:0]  xl, yl;
  logic [131:0] pp_ext;

  // limb select: cnt bit 0 picks x limb, bit 1 picks y limb
  assign xl = cnt[0] ? xq[65:33] : xq[32:0];
  assign yl = cnt[1] ? yq[65:33] : yq[32:0];

  // align the registered partial product
  always_comb begin
    unique case (pp_sh)
      2'd0:    pp_ext = {66'b0, pp};
      2'd1:    pp_ext = {33'b0, pp, 33'b0};
      2'd2:    pp_ext = {pp, 66'b0};
      default: pp_ext = '0;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: multiply one limb pair, add the previous one
  always_ff @(posedge clk) begin
    if (start) begin
      xq      <= x;
      yq      <= y;
      product <= '0;
    end else if (busy) begin
      pp    <= {33'b0, xl} * {33'b0, yl};
      pp_sh <= {1'b0, cnt[0]} + {1'b0, cnt[1]};
      if (cnt != 3'd0) product <= product + pp_ext;
    end
  end

endmodule
`default_nettype wire

// ----- src/sstc_isqrt.sv -----
// Bit-serial integer square root, one root bit per cycle.
`default_nettype none
module sstc_isqrt
  import sstc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic         half,    // radicand fits in the low 66 bits
  input  wire logic [131:0] rad,
  output logic              done,
  output logic [65:0]       root,
  output logic              rem_nz
);

  logic [131:0] xs;
  logic [66:0]  rem;
  logic [6:0]   cnt;
  logic [68:0]  rem_sh, trial, diff;
  logic         take;

  // one restoring step
  assign rem_sh = {rem, xs[131:130]};
  assign trial  = {1'b0, root, 2'b01};
  assign take   = rem_sh >= trial;
  assign diff   = rem_sh - trial;
  assign rem_nz = rem != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= half ? SQRT_STEPS_HALF : SQRT_STEPS_FULL;
      end else if (cnt != '0) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= half ? {rad[65:0], 66'b0} : rad;
      rem  <= '0;
      root <= '0;
    end else if (cnt != '0) begin
      xs   <= {xs[129:0], 2'b00};
      rem  <= take ? diff[66:0] : rem_sh[66:0];
      root <= {root[64:0], take};
    end
  end

endmodule
`default_nettype wire

// ----- src/sstc_dp.sv -----
// Datapath: target store, dot products, checks, square roots and divider.
`default_nettype none
module sstc_dp
  import sstc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            ctl,
  output dp_stat_t                st,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               cmd,
  input  wire logic signed [31:0] center_x,
  input  wire logic signed [31:0] center_y,
  input  wire logic signed [31:0] center_z,
  input  wire logic signed [31:0] move_x,
  input  wire logic signed [31:0] move_y,
  input  wire logic signed [31:0] move_z,
  input  wire logic [30:0]        radius,
  output logic                    hit,
  output logic [23:0]             contact_time,
  output logic [2:0]              outcome
);

  logic [31:0] min_motion_sq;
  logic [31:0] tgt_cx, tgt_cy, tgt_cz, tgt_mx, tgt_my, tgt_mz;
  logic [30:0] tgt_radius;
  logic        tgt_loaded;

  logic [31:0]  md [3];
  logic [31:0]  mv [3];
  logic [2:0]   neg;
  logic [31:0]  rsum;
  logic [65:0]  a, dd, bpos, bneg, nb, c;
  logic [63:0]  rsq;
  logic [33:0]  reach;
  logic [67:0]  reach_sq;
  logic [131:0] bb, ac, disc;
  logic [81:0]  drem;
  logic [88:0]  dsr;
  logic [23:0]  q;
  mul_sel_t     mul_dst;

  logic [32:0]  dif_d [3];
  logic [32:0]  dif_v [3];
  logic [31:0]  cin [3];
  logic [31:0]  tcin [3];
  logic [31:0]  vin [3];
  logic [31:0]  tvin [3];
  logic [65:0]  mx, my;
  logic         mul_done, sqrt_done, sqrt_rem_nz;
  logic [131:0] prod;
  logic [65:0]  root;
  logic [81:0]  num;

  assign cin  = '{center_x, center_y, center_z};
  assign tcin = '{tgt_cx, tgt_cy, tgt_cz};
  assign vin  = '{move_x, move_y, move_z};
  assign tvin = '{tgt_mx, tgt_my, tgt_mz};

  // exact 33-bit differences, focus minus target
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dif_d[k] = {cin[k][31], cin[k]} - {tcin[k][31], tcin[k]};
      dif_v[k] = {vin[k][31], vin[k]} - {tvin[k][31], tvin[k]};
    end
  end

  // config register and target store
  always_ff @(posedge clk) begin
    if (rst) begin
      min_motion_sq <= 32'd1;
      tgt_loaded    <= 1'b0;
      tgt_cx <= '0; tgt_cy <= '0; tgt_cz <= '0;
      tgt_mx <= '0; tgt_my <= '0; tgt_mz <= '0;
      tgt_radius <= '0;
    end else begin
      if (cfg_we) min_motion_sq <= cfg_wdata;
      if (ctl.capture && cmd == CMD_LOAD) begin
        tgt_cx <= center_x; tgt_cy <= center_y; tgt_cz <= center_z;
        tgt_mx <= move_x;   tgt_my <= move_y;   tgt_mz <= move_z;
        tgt_radius <= radius;
        tgt_loaded <= 1'b1;
      end
    end
  end

  // multiplier operand select
  always_comb begin
    unique case (ctl.mul_sel)
      SEL_VV0:   begin mx = {34'b0, mv[0]}; my = {34'b0, mv[0]}; end
      SEL_DD0:   begin mx = {34'b0, md[0]}; my = {34'b0, md[0]}; end
      SEL_DV0:   begin mx = {34'b0, md[0]}; my = {34'b0, mv[0]}; end
      SEL_VV1:   begin mx = {34'b0, mv[1]}; my = {34'b0, mv[1]}; end
      SEL_DD1:   begin mx = {34'b0, md[1]}; my = {34'b0, md[1]}; end
      SEL_DV1:   begin mx = {34'b0, md[1]}; my = {34'b0, mv[1]}; end
      SEL_VV2:   begin mx = {34'b0, mv[2]}; my = {34'b0, mv[2]}; end
      SEL_DD2:   begin mx = {34'b0, md[2]}; my = {34'b0, md[2]}; end
      SEL_DV2:   begin mx = {34'b0, md[2]}; my = {34'b0, mv[2]}; end
      SEL_RR:    begin mx = {34'b0, rsum};  my = {34'b0, rsum};  end
      SEL_REACH: begin mx = {32'b0, reach}; my = {32'b0, reach}; end
      SEL_BB:    begin mx = nb;             my = nb;             end
      SEL_AC:    begin mx = a;              my = c;              end
      default:   begin mx = '0;             my = '0;             end
    endcase
  end

  sstc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (ctl.mul_start),
    .x       (mx),
    .y       (my),
    .done    (mul_done),
    .product (prod)
  );

  sstc_isqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (ctl.sqrt_start),
    .half   (!ctl.sqrt_disc),
    .rad    (ctl.sqrt_disc ? disc : {66'b0, a}),
    .done   (sqrt_done),
    .root   (root),
    .rem_nz (sqrt_rem_nz)
  );

  // scaled numerator for the divider, zero when the root reaches -b
  assign num = (nb > root) ? {nb - root, 16'b0} : '0;

  // working registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      for (int k = 0; k < 3; k++) begin
        md[k]  <= dif_d[k][32] ? 32'(-dif_d[k]) : dif_d[k][31:0];
        mv[k]  <= dif_v[k][32] ? 32'(-dif_v[k]) : dif_v[k][31:0];
        neg[k] <= dif_d[k][32] ^ dif_v[k][32];
      end
      rsum <= {1'b0, tgt_radius} + {1'b0, radius};
      a    <= '0;
      dd   <= '0;
      bpos <= '0;
      bneg <= '0;
    end
    if (ctl.mul_start) mul_dst <= ctl.mul_sel;
    // store or accumulate a finished product
    if (mul_done) begin
      unique case (mul_dst)
        SEL_VV0, SEL_VV1, SEL_VV2: a  <= a + prod[65:0];
        SEL_DD0, SEL_DD1, SEL_DD2: dd <= dd + prod[65:0];
        SEL_DV0: if (neg[0]) bneg <= bneg + prod[65:0]; else bpos <= bpos + prod[65:0];
        SEL_DV1: if (neg[1]) bneg <= bneg + prod[65:0]; else bpos <= bpos + prod[65:0];
        SEL_DV2: if (neg[2]) bneg <= bneg + prod[65:0]; else bpos <= bpos + prod[65:0];
        SEL_RR:    rsq      <= prod[63:0];
        SEL_REACH: reach_sq <= prod[67:0];
        SEL_BB:    bb       <= prod;
        SEL_AC:    ac       <= prod;
        default:   ;
      endcase
    end
    if (ctl.calc_c) begin
      nb <= bneg - bpos;
      c  <= dd - {2'b0, rsq};
    end
    // reach uses ceil(sqrt(a))
    if (ctl.calc_reach) reach <= {2'b0, rsum} + root[33:0] + {33'b0, sqrt_rem_nz};
    if (ctl.calc_disc) disc <= bb - ac;
    // restoring divider, one quotient bit a step
    if (ctl.div_init) begin
      drem <= num;
      dsr  <= {a, 23'b0};
      q    <= '0;
    end else if (ctl.div_step) begin
      if ({7'b0, drem} >= dsr) begin
        drem <= drem - dsr[81:0];
        q    <= {q[22:0], 1'b1};
      end else begin
        q <= {q[22:0], 1'b0};
      end
      dsr <= {1'b0, dsr[88:1]};
    end
    // result register
    if (ctl.res_write) begin
      hit          <= ctl.res_outcome == OC_HIT;
      contact_time <= (ctl.res_outcome == OC_HIT) ? q : '0;
      outcome      <= ctl.res_outcome;
    end
  end

  // status toward the controller
  always_comb begin
    st.loaded     = tgt_loaded;
    st.mul_done   = mul_done;
    st.sqrt_done  = sqrt_done;
    st.no_motion  = a <= {34'b0, min_motion_sq};
    st.overlap    = dd <= {2'b0, rsq};
    st.separating = bpos >= bneg;
    st.out_reach  = {2'b0, dd} > reach_sq;
    st.no_root    = bb < ac;
  end

endmodule
`default_nettype wire

// ----- src/sstc_ctrl.sv -----
// Controller: sequences the datapath for one item at a time.
`default_nettype none
module sstc_ctrl
  import sstc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     cmd,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dp_cmd_t       ctl,
  input  wire dp_stat_t st
);

  state_t   state, state_next;
  mul_sel_t sel, sel_next;
  outcome_t oc, oc_next;
  logic [4:0] step, step_next;
  logic       accept;

  assign in_ready = state == ST_IDLE;
  assign accept   = in_valid && in_ready;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sel       <= SEL_VV0;
      oc        <= OC_HIT;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      oc    <= oc_next;
      step  <= step_next;
      if (ctl.res_write)  out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    sel_next   = sel;
    oc_next    = oc;
    step_next  = step;
    ctl        = '0;
    ctl.mul_sel     = sel;
    ctl.res_outcome = oc;
    ctl.capture     = accept;
    unique case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_TEST) begin
          if (st.loaded) begin
            sel_next   = SEL_VV0;
            state_next = ST_MUL;
          end else begin
            oc_next    = OC_NO_TARGET;
            state_next = ST_RESULT;
          end
        end
      end
      ST_MUL: begin
        ctl.mul_start = 1'b1;
        state_next    = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (st.mul_done) begin
          state_next = ST_MUL;
          unique case (sel)
            SEL_VV0:   sel_next = SEL_DD0;
            SEL_DD0:   sel_next = SEL_DV0;
            SEL_DV0:   sel_next = SEL_VV1;
            SEL_VV1:   sel_next = SEL_DD1;
            SEL_DD1:   sel_next = SEL_DV1;
            SEL_DV1:   sel_next = SEL_VV2;
            SEL_VV2:   sel_next = SEL_DD2;
            SEL_DD2:   sel_next = SEL_DV2;
            SEL_DV2:   sel_next = SEL_RR;
            SEL_RR:    state_next = ST_CHECK;
            SEL_REACH: state_next = ST_CHK_REACH;
            SEL_BB:    sel_next = SEL_AC;
            SEL_AC:    state_next = ST_CHK_ROOT;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      // early rejections in their fixed order
      ST_CHECK: begin
        state_next = ST_RESULT;
        priority if (st.no_motion) oc_next = OC_NO_MOTION;
        else if (st.overlap)       oc_next = OC_OVERLAP;
        else if (st.separating)    oc_next = OC_SEPARATING;
        else begin
          ctl.calc_c = 1'b1;
          state_next = ST_SQRT_A;
        end
      end
      ST_SQRT_A: begin
        ctl.sqrt_start = 1'b1;
        state_next     = ST_SQRT_A_WAIT;
      end
      ST_SQRT_A_WAIT: begin
        if (st.sqrt_done) begin
          ctl.calc_reach = 1'b1;
          sel_next       = SEL_REACH;
          state_next     = ST_MUL;
        end
      end
      ST_CHK_REACH: begin
        if (st.out_reach) begin
          oc_next    = OC_OUT_REACH;
          state_next = ST_RESULT;
        end else begin
          sel_next   = SEL_BB;
          state_next = ST_MUL;
        end
      end
      ST_CHK_ROOT: begin
        if (st.no_root) begin
          oc_next    = OC_NO_ROOT;
          state_next = ST_RESULT;
        end else begin
          ctl.calc_disc = 1'b1;
          state_next    = ST_SQRT_D;
        end
      end
      ST_SQRT_D: begin
        ctl.sqrt_start = 1'b1;
        ctl.sqrt_disc  = 1'b1;
        state_next     = ST_SQRT_D_WAIT;
      end
      ST_SQRT_D_WAIT: begin
        ctl.sqrt_disc = 1'b1;
        if (st.sqrt_done) begin
          ctl.div_init = 1'b1;
          step_next    = '0;
          state_next   = ST_DIV;
        end
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        step_next    = step + 5'd1;
        if (step == DIV_LAST) begin
          oc_next    = OC_HIT;
          state_next = ST_RESULT;
        end
      end
      // wait for the output register to free up
      ST_RESULT: begin
        if (!out_valid || out_ready) begin
          ctl.res_write = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/swept_sphere_contact_time_core.sv -----
// Top level of the swept sphere contact time core.
// A load item (cmd 0) stores the target sphere when accepted and gives no result.
// A test item (cmd 1) gives one result, sooner for an early rejection (no motion,
// overlap or separation) than for a hit. The time is set by the single 33x33
// multiplier, which forms each of up to 13 products in four partial products,
// and by the square root unit, which makes one root bit per cycle (33 bits for
// the reach bound, 66 for the discriminant), followed by 24 divider steps. One
// item is worked at a time; the finished result sits in an output register so
// the next item is taken while it waits.
`default_nettype none
module swept_sphere_contact_time_core
  import sstc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               cmd,
  input  wire logic signed [31:0] center_x,
  input  wire logic signed [31:0] center_y,
  input  wire logic signed [31:0] center_z,
  input  wire logic signed [31:0] move_x,
  input  wire logic signed [31:0] move_y,
  input  wire logic signed [31:0] move_z,
  input  wire logic [30:0]        radius,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    hit,
  output logic [23:0]             contact_time,
  output logic [2:0]              outcome
);

  dp_cmd_t  ctl;
  dp_stat_t st;

  sstc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .st        (st)
  );

  sstc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .st           (st),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .center_x     (center_x),
    .center_y     (center_y),
    .center_z     (center_z),
    .move_x       (move_x),
    .move_y       (move_y),
    .move_z       (move_z),
    .radius       (radius),
    .hit          (hit),
    .contact_time (contact_time),
    .outcome      (outcome)
  );

endmodule
`default_nettype wire
